/* src/rmq_pkg.sv */
package rmq_pkg;

    // Which component carries the half root; AX_W marks a positive trace
    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z,
        AX_W
    } t_axis;

endpackage

/* src/rmq_sqrt.sv */
module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int RW  = 32,
    parameter int SBW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [RW-1:0]       i_rad,
    input  logic [SBW-1:0]      i_sb,
    output logic                o_valid,
    output logic [RW/2-1:0]     o_root,
    output logic [SBW-1:0]      o_sb
);

    localparam int SW = RW / 2;

    logic              r_v    [SW];
    logic [RW-1:0]     r_rad  [SW];
    logic [SW+1:0]     r_rem  [SW];
    logic [SW-1:0]     r_root [SW];
    logic [SBW-1:0]    r_sb   [SW];

    // One root bit per stage, two radicand bits consumed per stage
    for (genvar g = 0; g < SW; g++) begin : g_stage
        logic           p_v;
        logic [RW-1:0]  p_rad;
        logic [SW+1:0]  p_rem;
        logic [SW-1:0]  p_root;
        logic [SBW-1:0] p_sb;
        logic [SW+1:0]  n_sh;
        logic [SW+1:0]  n_trial;
        logic           n_ge;

        if (g == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_sb   = i_sb;
        end else begin : g_next
            assign p_v    = r_v[g-1];
            assign p_rad  = r_rad[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_sb   = r_sb[g-1];
        end

        assign n_sh    = {p_rem[SW-1:0], p_rad[RW-1:RW-2]};
        assign n_trial = {p_root, 2'b01};
        assign n_ge    = (n_sh >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= p_v;
            end
            r_rad[g]  <= p_rad << 2;
            r_rem[g]  <= n_ge ? (n_sh - n_trial) : n_sh;
            r_root[g] <= {p_root[SW-2:0], n_ge};
            r_sb[g]   <= p_sb;
        end
    end

    assign o_valid = r_v[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_sb    = r_sb[SW-1];

endmodule

/* src/rmq_div.sv */
module rmq_div
    import rmq_pkg::*;
#(
    parameter int NW    = 33,
    parameter int DW    = 18,
    parameter int LANES = 3,
    parameter int SBW   = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [LANES-1:0][NW-1:0]   i_num,
    input  logic [DW-1:0]              i_den,
    input  logic [SBW-1:0]             i_sb,
    output logic                       o_valid,
    output logic [LANES-1:0][NW-1:0]   o_quo,
    output logic [SBW-1:0]             o_sb
);

    logic                       r_v   [NW];
    logic [LANES-1:0][NW-1:0]   r_num [NW];
    logic [LANES-1:0][DW:0]     r_rem [NW];
    logic [LANES-1:0][NW-1:0]   r_quo [NW];
    logic [DW-1:0]              r_den [NW];
    logic [SBW-1:0]             r_sb  [NW];

    // Restoring division, one quotient bit per stage, lanes share the divisor
    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic                     p_v;
        logic [LANES-1:0][NW-1:0] p_num;
        logic [LANES-1:0][DW:0]   p_rem;
        logic [LANES-1:0][NW-1:0] p_quo;
        logic [DW-1:0]            p_den;
        logic [SBW-1:0]           p_sb;

        if (g == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_num = i_num;
            assign p_rem = '0;
            assign p_quo = '0;
            assign p_den = i_den;
            assign p_sb  = i_sb;
        end else begin : g_next
            assign p_v   = r_v[g-1];
            assign p_num = r_num[g-1];
            assign p_rem = r_rem[g-1];
            assign p_quo = r_quo[g-1];
            assign p_den = r_den[g-1];
            assign p_sb  = r_sb[g-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DW:0] n_sh;
            logic        n_ge;

            assign n_sh = {p_rem[l][DW-1:0], p_num[l][NW-1]};
            assign n_ge = (n_sh >= {1'b0, p_den});

            always_ff @(posedge i_clk) begin
                r_num[g][l] <= p_num[l] << 1;
                r_rem[g][l] <= n_ge ? (n_sh - {1'b0, p_den}) : n_sh;
                r_quo[g][l] <= {p_quo[l][NW-2:0], n_ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= p_v;
            end
            r_den[g] <= p_den;
            r_sb[g]  <= p_sb;
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_quo[NW-1];
    assign o_sb    = r_sb[NW-1];

endmodule

/* src/rotation_matrix_to_quaternion_core.sv */
// Rotation matrix to quaternion, Shepperd's method, fixed point.
// Input: raise start with the nine entries i_m00..i_m22; the transfer happens
// at a rising edge where start is high and busy is low. busy is low at all
// times once reset has been released, so a new matrix may enter every cycle.
// Output: o_valid pulses for one cycle with o_qx, o_qy, o_qz, o_qw and
// o_saturated; the receiver takes it in that cycle and cannot stall.
// Path: the input register, the square-root stages, the divider operand
// register, the divider stages and the output register, with SW = root bits
// (one per square-root stage) and NW = quotient bits (one per divider stage).
// At 16/14 bits SW = 16 and NW = 33. Throughput: one matrix per cycle, set
// by the fully pipelined root and divider stages.
// Reset (synchronous, active low) empties the pipeline; items in flight are
// dropped and busy stays high until the cycle after reset is released.
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_m00,
    input  logic signed [DATA_WIDTH-1:0] i_m01,
    input  logic signed [DATA_WIDTH-1:0] i_m02,
    input  logic signed [DATA_WIDTH-1:0] i_m10,
    input  logic signed [DATA_WIDTH-1:0] i_m11,
    input  logic signed [DATA_WIDTH-1:0] i_m12,
    input  logic signed [DATA_WIDTH-1:0] i_m20,
    input  logic signed [DATA_WIDTH-1:0] i_m21,
    input  logic signed [DATA_WIDTH-1:0] i_m22,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_qx,
    output logic signed [DATA_WIDTH-1:0] o_qy,
    output logic signed [DATA_WIDTH-1:0] o_qz,
    output logic signed [DATA_WIDTH-1:0] o_qw,
    output logic                         o_saturated
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int MW  = (W > F) ? W : F;
    localparam int AW  = MW + 3;
    localparam int RW0 = AW - 1 + F;
    localparam int RW  = RW0 + (RW0 % 2);
    localparam int SW  = RW / 2;
    localparam int NWD = W + F + 3;
    localparam int DW  = SW + 2;
    localparam int EW  = W + 1;
    localparam int SB1 = 3 * EW + 2;
    localparam int SB2 = 3 + SW + 1 + 2;

    localparam logic signed [AW-1:0] ONE  = {{(AW-1){1'b0}}, 1'b1} << F;
    localparam logic [W-1:0]         HI_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]         LO_W = {1'b1, {(W-1){1'b0}}};
    localparam logic [NWD-1:0]       HI_P = {{(NWD-W){1'b0}}, HI_W};
    localparam logic [NWD-1:0]       HI_N = {{(NWD-W){1'b0}}, LO_W};

    // Clamp a magnitude with sign to the output range; top bit flags a clamp
    function automatic logic [W:0] f_clamp(input logic [NWD-1:0] mag, input logic neg);
        logic [NWD-1:0] t;
        t = -mag;
        if (!neg) begin
            if (mag > HI_P) return {1'b1, HI_W};
            return {1'b0, mag[W-1:0]};
        end
        if (mag > HI_N) return {1'b1, LO_W};
        return {1'b0, t[W-1:0]};
    endfunction

    logic r_rdy;
    logic n_acc;

    assign busy  = !r_rdy;
    assign n_acc = start && r_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end

    // Stage 0: trace, axis pick, radicand and the three numerators
    logic signed [AW-1:0] n_e00, n_e11, n_e22, n_trace, n_di, n_dj, n_dk, n_arg;
    logic                 n_tpos;
    t_axis                n_axis;
    logic [RW-1:0]        n_rad;
    logic signed [EW-1:0] n_n0, n_n1, n_n2;

    assign n_e00   = AW'(i_m00);
    assign n_e11   = AW'(i_m11);
    assign n_e22   = AW'(i_m22);
    assign n_trace = n_e00 + n_e11 + n_e22;
    assign n_tpos  = (n_trace > 0);

    always_comb begin
        t_axis ax;
        ax = AX_X;
        if (i_m11 > i_m00) ax = AX_Y;
        if (ax == AX_Y) begin
            if (i_m22 > i_m11) ax = AX_Z;
        end else begin
            if (i_m22 > i_m00) ax = AX_Z;
        end
        n_axis = n_tpos ? AX_W : ax;
        unique case (ax)
            AX_Y: begin
                n_di = n_e11; n_dj = n_e22; n_dk = n_e00;
            end
            AX_Z: begin
                n_di = n_e22; n_dj = n_e00; n_dk = n_e11;
            end
            default: begin
                n_di = n_e00; n_dj = n_e11; n_dk = n_e22;
            end
        endcase
        n_arg = n_tpos ? (n_trace + ONE) : (n_di - n_dj - n_dk + ONE);
        n_rad = n_arg[AW-1] ? '0 : (RW'(n_arg[AW-2:0]) << F);
        unique case (n_axis)
            AX_W: begin
                n_n0 = EW'(i_m21) - EW'(i_m12);
                n_n1 = EW'(i_m02) - EW'(i_m20);
                n_n2 = EW'(i_m10) - EW'(i_m01);
            end
            AX_X: begin
                n_n0 = EW'(i_m10) + EW'(i_m01);
                n_n1 = EW'(i_m20) + EW'(i_m02);
                n_n2 = EW'(i_m21) - EW'(i_m12);
            end
            AX_Y: begin
                n_n0 = EW'(i_m21) + EW'(i_m12);
                n_n1 = EW'(i_m01) + EW'(i_m10);
                n_n2 = EW'(i_m02) - EW'(i_m20);
            end
            default: begin
                n_n0 = EW'(i_m02) + EW'(i_m20);
                n_n1 = EW'(i_m12) + EW'(i_m21);
                n_n2 = EW'(i_m10) - EW'(i_m01);
            end
        endcase
    end

    logic             r0_valid;
    logic [RW-1:0]    r0_rad;
    logic [SB1-1:0]   r0_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= n_acc;
        end
        r0_rad <= n_rad;
        r0_sb  <= {n_n2, n_n1, n_n0, n_axis};
    end

    // Square root pipeline
    logic            q_valid;
    logic [SW-1:0]   q_root;
    logic [SB1-1:0]  q_sb;

    rmq_sqrt #(.RW(RW), .SBW(SB1)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_valid),
        .i_rad   (r0_rad),
        .i_sb    (r0_sb),
        .o_valid (q_valid),
        .o_root  (q_root),
        .o_sb    (q_sb)
    );

    // Stage 1: dividend with rounding term, divisor 4s, signs
    logic [2:0][NWD-1:0] r1_num;
    logic [DW-1:0]       r1_den;
    logic [SB2-1:0]      r1_sb;
    logic                r1_valid;

    always_ff @(posedge i_clk) begin
        logic signed [EW-1:0] nv;
        logic [EW-1:0]        mag;
        logic [2:0]           neg;
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= q_valid;
        end
        for (int l = 0; l < 3; l++) begin
            nv     = q_sb[2 + l*EW +: EW];
            neg[l] = nv[EW-1];
            mag    = neg[l] ? -nv : nv;
            r1_num[l] <= NWD'({mag, {(F+1){1'b0}}}) + NWD'({q_root, 1'b0});
        end
        r1_den <= {q_root, 2'b00};
        r1_sb  <= {neg, {1'b0, q_root[SW-1:1]}, (q_root == '0), q_sb[1:0]};
    end

    // Divider pipeline, three lanes
    logic                d_valid;
    logic [2:0][NWD-1:0] d_quo;
    logic [SB2-1:0]      d_sb;

    rmq_div #(.NW(NWD), .DW(DW), .LANES(3), .SBW(SB2)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_valid),
        .i_num   (r1_num),
        .i_den   (r1_den),
        .i_sb    (r1_sb),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_sb    (d_sb)
    );

    // Output stage: clamp and place components by axis
    logic [W:0]    n_c0, n_c1, n_c2, n_ch;
    t_axis         n_oax;
    logic [W-1:0]  n_qx, n_qy, n_qz, n_qw;

    always_comb begin
        logic [2:0]    neg;
        logic [SW-1:0] half;
        logic          zero;
        neg   = d_sb[SB2-1 -: 3];
        half  = d_sb[3 +: SW];
        zero  = d_sb[2];
        n_oax = t_axis'(d_sb[1:0]);
        n_c0  = zero ? '0 : f_clamp(d_quo[0], neg[0]);
        n_c1  = zero ? '0 : f_clamp(d_quo[1], neg[1]);
        n_c2  = zero ? '0 : f_clamp(d_quo[2], neg[2]);
        n_ch  = f_clamp(NWD'(half), 1'b0);
        unique case (n_oax)
            AX_W: begin
                n_qx = n_c0[W-1:0]; n_qy = n_c1[W-1:0];
                n_qz = n_c2[W-1:0]; n_qw = n_ch[W-1:0];
            end
            AX_X: begin
                n_qx = n_ch[W-1:0]; n_qy = n_c0[W-1:0];
                n_qz = n_c1[W-1:0]; n_qw = n_c2[W-1:0];
            end
            AX_Y: begin
                n_qy = n_ch[W-1:0]; n_qz = n_c0[W-1:0];
                n_qx = n_c1[W-1:0]; n_qw = n_c2[W-1:0];
            end
            default: begin
                n_qz = n_ch[W-1:0]; n_qx = n_c0[W-1:0];
                n_qy = n_c1[W-1:0]; n_qw = n_c2[W-1:0];
            end
        endcase
    end

    logic         r_valid;
    logic         r_sat;
    logic [W-1:0] r_qx, r_qy, r_qz, r_qw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            r_valid <= d_valid;
            r_sat   <= d_valid && (n_c0[W] || n_c1[W] || n_c2[W] || n_ch[W]);
        end
        r_qx <= n_qx;
        r_qy <= n_qy;
        r_qz <= n_qz;
        r_qw <= n_qw;
    end

    assign o_valid     = r_valid;
    assign o_saturated = r_sat;
    assign o_qx        = r_qx;
    assign o_qy        = r_qy;
    assign o_qz        = r_qz;
    assign o_qw        = r_qw;

endmodule

/* src/rmq_checker.sv */
module rmq_checker
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_saturated
);

    localparam int MW  = (DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS;
    localparam int RW0 = MW + 2 + FRAC_BITS;
    localparam int SW  = (RW0 + (RW0 % 2)) / 2;
    localparam int LAT = SW + DATA_WIDTH + FRAC_BITS + 3 + 3;

    // Every accepted matrix shows up exactly after the pipeline latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing after pipeline latency");

    // No result without a matching transfer
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without accepted matrix");

    // Flag only travels with a result
    a_sat_valid: assert property (@(posedge i_clk)
        o_saturated |-> o_valid)
        else $error("saturated flag without result");

    // Pipeline never pushes back once out of reset
    a_no_busy: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> !busy)
        else $error("busy raised outside reset");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_rmq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_saturated (o_saturated)
);
